/* rtl/core/scag_pkg.sv */
// Shared types and constants for the strided copy address generator.
`timescale 1ns / 1ps
`default_nettype none
package scag_pkg;

   // Dimension registers, outermost first.
   localparam int NUM_REGS      = 4;
   localparam int CFG_BITS      = 64;
   localparam int CSR_IDX_BITS  = 3;
   localparam int STRIDE_BITS   = 24;
   localparam int OFFSET_BITS   = 32;
   localparam int ADDR_W        = 32;

   // Field positions inside a dimension register.
   localparam int SIZE_LSB       = 48;
   localparam int SRC_STRIDE_LSB = 24;
   localparam int DST_STRIDE_LSB = 0;

   // Reset value of a dimension register: size 1, zero strides.
   localparam logic [CFG_BITS-1:0] DIM_RESET = 64'h0001_0000_0000_0000;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_DIM_OUTER   = 3'd0,
      CSR_DIM_SECOND  = 3'd1,
      CSR_DIM_THIRD   = 3'd2,
      CSR_DIM_INNER   = 3'd3,
      CSR_DEST_OFFSET = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic empty;   // some active dimension has size zero
      logic last;    // this beat is the final element of the copy
   } odo_status_type;

endpackage
`default_nettype wire

/* rtl/core/scag_odometer.sv */
// Index odometer: restart, empty-copy check and carry into outer dimensions.
`timescale 1ns / 1ps
`default_nettype none
module scag_odometer #(
   parameter int DIMS      = 4,
   parameter int SIZE_BITS = 16
) (
   input  var logic                 restart,
   input  var logic [SIZE_BITS-1:0] size     [scag_pkg::NUM_REGS],
   input  var logic [SIZE_BITS-1:0] idx_cur  [scag_pkg::NUM_REGS],
   output var logic [SIZE_BITS-1:0] idx_used [scag_pkg::NUM_REGS],
   output var logic [SIZE_BITS-1:0] idx_next [scag_pkg::NUM_REGS],
   output var scag_pkg::odo_status_type status
);
   import scag_pkg::*;

   localparam int ACTIVE = (DIMS < NUM_REGS) ? DIMS : NUM_REGS;
   localparam int FIRST  = NUM_REGS - ((ACTIVE < 1) ? 1 : ACTIVE);

   always_comb begin
      for (int d = 0; d < NUM_REGS; d++) begin
         idx_used[d] = (restart || d < FIRST) ? '0 : idx_cur[d];
      end
   end

   always_comb begin
      logic carry;
      logic empty;
      carry = 1'b1;
      empty = 1'b0;
      for (int d = 0; d < NUM_REGS; d++) begin
         if (d >= FIRST && size[d] == '0) begin
            empty = 1'b1;
         end
      end
      // Innermost first; wrap when the next value reaches the size.
      for (int d = NUM_REGS - 1; d >= 0; d--) begin
         if (d < FIRST) begin
            idx_next[d] = '0;
         end else if (!carry) begin
            idx_next[d] = idx_used[d];
         end else if ({1'b0, idx_used[d]} + 1'b1 >= {1'b0, size[d]}) begin
            idx_next[d] = '0;
         end else begin
            idx_next[d] = idx_used[d] + 1'b1;
            carry       = 1'b0;
         end
      end
      // Empty copy leaves the indices where they are.
      if (empty) begin
         for (int d = 0; d < NUM_REGS; d++) begin
            idx_next[d] = idx_used[d];
         end
      end
      status.empty = empty;
      status.last  = carry;
   end

endmodule
`default_nettype wire

/* rtl/core/strided_copy_address_generator_top.sv */
// Top level of the strided copy address generator.
`timescale 1ns / 1ps
`default_nettype none
// Emits one source/destination element address pair per accepted req beat
// for an up to four-dimensional strided copy, innermost dimension fastest.
// Each beat first clears the indices when its restart bit is set. The
// block sustains one beat per cycle while rsp_tready is high: the index
// odometer updates in the cycle a beat is taken, then a multiply stage
// forms index times stride per dimension and a sum stage adds the products
// and the destination offset. A beat passes the stage A index, stage B
// product and stage C sum registers before rsp_tvalid rises. Each stage
// advances on its own, so bubbles close up and a stalled rsp beat does not
// block req while an earlier stage is free. A copy with any active size
// of zero gives no rsp beat. rsp_tlast marks the final element, after
// which the indices wrap to zero. Addresses wrap modulo 2^min(ADDR_BITS,32)
// and are presented in 32 bits. Write the csr registers only while no beat
// is in flight; csr_ready is always high. Outer dimension registers beyond
// DIMS are ignored and act as size 1 with zero strides.
module strided_copy_address_generator_top #(
   parameter int DIMS      = 4,
   parameter int ADDR_BITS = 32,
   parameter int SIZE_BITS = 16
) (
   input  var logic        clock,
   input  var logic        reset,
   // req beat
   input  var logic        req_tvalid,
   output var logic        req_tready,
   input  var logic [7:0]  req_tdata,    // [0] restart, [7:1] zero
   // rsp beat
   output var logic        rsp_tvalid,
   input  var logic        rsp_tready,
   output var logic [63:0] rsp_tdata,    // [31:0] src_address, [63:32] dest_address
   output var logic        rsp_tlast,    // last_element
   // register writes
   input  var logic        csr_valid,
   output var logic        csr_ready,
   input  var logic [scag_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  var logic [scag_pkg::CFG_BITS-1:0]     csr_data
);
   import scag_pkg::*;

   localparam int ACTIVE    = (DIMS < NUM_REGS) ? DIMS : NUM_REGS;
   localparam int FIRST     = NUM_REGS - ((ACTIVE < 1) ? 1 : ACTIVE);
   localparam int OUT_BITS  = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
   localparam logic [ADDR_W-1:0] ADDR_MASK =
      (OUT_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'd1 << OUT_BITS) - 64'd1);

   // ---------------- configuration ----------------
   logic [CFG_BITS-1:0]    dim_ff [NUM_REGS];
   logic [CFG_BITS-1:0]    dim_in [NUM_REGS];
   logic [OFFSET_BITS-1:0] offset_ff;
   logic [OFFSET_BITS-1:0] offset_in;

   assign csr_ready = 1'b1;

   always_comb begin
      dim_in    = dim_ff;
      offset_in = offset_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DIM_OUTER:   dim_in[0] = csr_data;
            CSR_DIM_SECOND:  dim_in[1] = csr_data;
            CSR_DIM_THIRD:   dim_in[2] = csr_data;
            CSR_DIM_INNER:   dim_in[3] = csr_data;
            CSR_DEST_OFFSET: offset_in = csr_data[OFFSET_BITS-1:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < NUM_REGS; d++) begin
            dim_ff[d] <= DIM_RESET;
         end
         offset_ff <= '0;
      end else begin
         dim_ff    <= dim_in;
         offset_ff <= offset_in;
      end
   end

   // Per-dimension fields; outer dimensions beyond DIMS act as size 1.
   logic [SIZE_BITS-1:0]   size       [NUM_REGS];
   logic [STRIDE_BITS-1:0] src_stride [NUM_REGS];
   logic [STRIDE_BITS-1:0] dst_stride [NUM_REGS];

   always_comb begin
      for (int d = 0; d < NUM_REGS; d++) begin
         if (d < FIRST) begin
            size[d]       = SIZE_BITS'(1);
            src_stride[d] = '0;
            dst_stride[d] = '0;
         end else begin
            size[d]       = dim_ff[d][SIZE_LSB +: SIZE_BITS];
            src_stride[d] = dim_ff[d][SRC_STRIDE_LSB +: STRIDE_BITS];
            dst_stride[d] = dim_ff[d][DST_STRIDE_LSB +: STRIDE_BITS];
         end
      end
   end

   // ---------------- pipeline handshake ----------------
   logic a_valid_ff;
   logic b_valid_ff;
   logic rsp_valid_ff;
   logic c_load;
   logic b_load;
   logic a_load;
   logic req_accept;

   // A stage takes new data when it is empty or its content moves on.
   assign c_load     = !rsp_valid_ff || rsp_tready;
   assign b_load     = !b_valid_ff || c_load;
   assign a_load     = !a_valid_ff || b_load;
   assign req_tready = a_load;
   assign req_accept = req_tvalid && a_load;

   // ---------------- odometer ----------------
   logic [SIZE_BITS-1:0] idx_ff   [NUM_REGS];
   logic [SIZE_BITS-1:0] idx_in   [NUM_REGS];
   logic [SIZE_BITS-1:0] idx_used [NUM_REGS];
   logic [SIZE_BITS-1:0] idx_next [NUM_REGS];
   odo_status_type       odo_status;

   scag_odometer #(
      .DIMS      (DIMS),
      .SIZE_BITS (SIZE_BITS)
   ) u_odometer (
      .restart  (req_tdata[0]),
      .size     (size),
      .idx_cur  (idx_ff),
      .idx_used (idx_used),
      .idx_next (idx_next),
      .status   (odo_status)
   );

   always_comb begin
      for (int d = 0; d < NUM_REGS; d++) begin
         idx_in[d] = req_accept ? idx_next[d] : idx_ff[d];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < NUM_REGS; d++) begin
            idx_ff[d] <= '0;
         end
      end else begin
         idx_ff <= idx_in;
      end
   end

   // ---------------- stage A: indices of this element ----------------
   logic [SIZE_BITS-1:0] a_idx_ff [NUM_REGS];
   logic                 a_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_load) begin
         a_valid_ff <= req_accept && !odo_status.empty;
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_idx_ff  <= idx_used;
         a_last_ff <= odo_status.last;
      end
   end

   // ---------------- stage B: index times stride ----------------
   // Only the low address bits survive the wrap, so keep the products there.
   logic [ADDR_W-1:0] b_src_ff [NUM_REGS];
   logic [ADDR_W-1:0] b_dst_ff [NUM_REGS];
   logic              b_last_ff;
   logic [ADDR_W-1:0] src_prod [NUM_REGS];
   logic [ADDR_W-1:0] dst_prod [NUM_REGS];

   always_comb begin
      for (int d = 0; d < NUM_REGS; d++) begin
         src_prod[d] = ADDR_W'(a_idx_ff[d]) * ADDR_W'(src_stride[d]);
         dst_prod[d] = ADDR_W'(a_idx_ff[d]) * ADDR_W'(dst_stride[d]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_load) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_load) begin
         for (int d = 0; d < NUM_REGS; d++) begin
            b_src_ff[d] <= src_prod[d];
            b_dst_ff[d] <= dst_prod[d];
         end
         b_last_ff <= a_last_ff;
      end
   end

   // ---------------- stage C: sum, offset and wrap ----------------
   logic [ADDR_W-1:0] src_sum;
   logic [ADDR_W-1:0] dst_sum;
   logic [ADDR_W-1:0] rsp_src_ff;
   logic [ADDR_W-1:0] rsp_dst_ff;
   logic              rsp_last_ff;

   always_comb begin
      src_sum = '0;
      dst_sum = offset_ff;
      for (int d = 0; d < NUM_REGS; d++) begin
         src_sum = src_sum + b_src_ff[d];
         dst_sum = dst_sum + b_dst_ff[d];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (c_load) begin
         rsp_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (c_load) begin
         rsp_src_ff  <= src_sum & ADDR_MASK;
         rsp_dst_ff  <= dst_sum & ADDR_MASK;
         rsp_last_ff <= b_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_dst_ff, rsp_src_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire
